// ===== src/tsmd_pkg.sv =====
`default_nettype none
package tsmd_pkg;

    // Field widths of one timestamp.
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int STAMP_W  = YEAR_W + MONTH_W + DAY_W + HOUR_W + MINUTE_W;

    // Linear day count and minute count of one stamp.
    localparam int DAYS_W = 23;
    localparam int MINS_W = 34;

    // Result width and padded stream widths.
    localparam int ELAPSED_W = 33;
    localparam int IN_DATA_W  = ((2 * STAMP_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((ELAPSED_W + 7) / 8) * 8;

    localparam int MINUTES_PER_DAY  = 1440;
    localparam int MINUTES_PER_HOUR = 60;
    localparam int DAYS_PER_YEAR    = 365;

    // floor(t / 25) = (t * RECIP25) >> RECIP25_SHIFT for t < 4096.
    localparam int RECIP25       = 5243;
    localparam int RECIP25_SHIFT = 17;

    // Days in the months before a month code, common year. Codes above
    // twelve count the whole year; code zero counts nothing.
    localparam logic [8:0] DAYS_BEFORE_MONTH [16] = '{
        9'd0,   9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365, 9'd365, 9'd365
    };

    // First month code after February.
    localparam logic [MONTH_W-1:0] MONTH_MARCH = 4'd3;

    // Per-stage advance enables of the stamp pipeline.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } adv_t;

endpackage
`default_nettype wire

// ===== src/timestamp_minute_difference_core.sv =====
`default_nettype none
// Throughput: one word per cycle while the output is not stalled; each stage
// refills whenever its successor moves or it is empty, so up to four more
// words enter while a result waits.
// Reset (rst_n low, asynchronous) clears only the stage valid bits; the
// datapath registers are not reset.

// Each stamp becomes a linear minute count in the proleptic Gregorian
// calendar: stage 1 forms year/4 times a reciprocal of 25 (one small
// multiplier), stage 2 finds the century test and the year days, stage 3
// sums the leap-day count, month days and day, stage 4 multiplies by the
// minutes per day. Stage 5 takes the absolute difference of the two counts
// and saturates it to 33 bits in the output register.
module timestamp_minute_difference_core
(
    input  wire                                clk,
    input  wire                                rst_n,
    // Input words: both timestamps.
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    // From bit 0 up: first_year, first_month, first_day, first_hour,
    // first_minute, second_year, second_month, second_day, second_hour,
    // second_minute, zero padding.
    input  wire  [tsmd_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // Result words.
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    // From bit 0 up: elapsed_minutes, zero padding.
    output logic [tsmd_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    localparam int SW = tsmd_pkg::STAMP_W;
    localparam int MW = tsmd_pkg::MINS_W;
    localparam int EW = tsmd_pkg::ELAPSED_W;

    // Field offsets inside one stamp.
    localparam int MO = tsmd_pkg::YEAR_W;
    localparam int DO = MO + tsmd_pkg::MONTH_W;
    localparam int HO = DO + tsmd_pkg::DAY_W;
    localparam int NO = HO + tsmd_pkg::HOUR_W;

    // Valid bits of the five stages.
    logic [4:0] vld_reg, vld_next;
    logic [4:0] rdy;

    tsmd_pkg::adv_t adv;

    logic [SW-1:0] stamp_a, stamp_b;
    logic [MW-1:0] mins_a, mins_b;
    logic [MW-1:0] diff;
    logic [EW-1:0] elapsed_next;
    logic [EW-1:0] elapsed_reg;

    // A stage may load when it is empty or its contents move on.
    always_comb
    begin
        rdy[4] = !vld_reg[4] || m_axis_tready;
        for (int k = 3; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        adv.s1 = rdy[0];
        adv.s2 = rdy[1];
        adv.s3 = rdy[2];
        adv.s4 = rdy[3];

        vld_next[0] = rdy[0] ? s_axis_tvalid : vld_reg[0];
        for (int k = 1; k < 5; k++)
        begin
            vld_next[k] = rdy[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    assign stamp_a = s_axis_tdata[SW-1:0];
    assign stamp_b = s_axis_tdata[2*SW-1:SW];

    tsmd_stamp u_stamp_a
    (
        .clk    (clk),
        .adv    (adv),
        .year   (stamp_a[MO-1:0]),
        .month  (stamp_a[DO-1:MO]),
        .day    (stamp_a[HO-1:DO]),
        .hour   (stamp_a[NO-1:HO]),
        .minute (stamp_a[SW-1:NO]),
        .mins   (mins_a)
    );

    tsmd_stamp u_stamp_b
    (
        .clk    (clk),
        .adv    (adv),
        .year   (stamp_b[MO-1:0]),
        .month  (stamp_b[DO-1:MO]),
        .day    (stamp_b[HO-1:DO]),
        .hour   (stamp_b[NO-1:HO]),
        .minute (stamp_b[SW-1:NO]),
        .mins   (mins_b)
    );

    // Order the counts, subtract, and clamp anything past 33 bits.
    always_comb
    begin
        diff = (mins_a >= mins_b) ? (mins_a - mins_b) : (mins_b - mins_a);
        if (diff[MW-1:EW] != '0)
        begin
            elapsed_next = '1;
        end
        else
        begin
            elapsed_next = diff[EW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[4])
        begin
            elapsed_reg <= elapsed_next;
        end
    end

    assign s_axis_tready = rdy[0];
    assign m_axis_tvalid = vld_reg[4];
    assign m_axis_tdata  = tsmd_pkg::OUT_DATA_W'(elapsed_reg);

endmodule
`default_nettype wire

// ===== src/tsmd_stamp.sv =====
`default_nettype none
// Maps one timestamp to a linear minute count over four register stages.
module tsmd_stamp
(
    input  wire                               clk,
    input  wire tsmd_pkg::adv_t               adv,
    input  wire  [tsmd_pkg::YEAR_W-1:0]       year,
    input  wire  [tsmd_pkg::MONTH_W-1:0]      month,
    input  wire  [tsmd_pkg::DAY_W-1:0]        day,
    input  wire  [tsmd_pkg::HOUR_W-1:0]       hour,
    input  wire  [tsmd_pkg::MINUTE_W-1:0]     minute,
    output logic [tsmd_pkg::MINS_W-1:0]       mins
);

    localparam int PROD_W = 25;
    localparam int Q_W    = 8;

    // Stage 1: year / 4 times the reciprocal of 25.
    logic [tsmd_pkg::YEAR_W-1:0]   y1_reg;
    logic [tsmd_pkg::MONTH_W-1:0]  m1_reg;
    logic [tsmd_pkg::DAY_W-1:0]    d1_reg;
    logic [tsmd_pkg::HOUR_W-1:0]   h1_reg;
    logic [tsmd_pkg::MINUTE_W-1:0] n1_reg;
    logic [PROD_W-1:0]             prod1_reg, prod1_next;

    // Stage 2: century test, year days, month days.
    logic [Q_W-1:0]                q2_reg, q2_next;
    logic                          div100_2_reg, div100_2_next;
    logic                          div4_2_reg, div4_2_next;
    logic [12:0]                   ceil4_2_reg, ceil4_2_next;
    logic [tsmd_pkg::DAYS_W-1:0]   yd2_reg, yd2_next;
    logic [9:0]                    md2_reg, md2_next;
    logic                          late2_reg, late2_next;
    logic [tsmd_pkg::HOUR_W-1:0]   h2_reg;
    logic [tsmd_pkg::MINUTE_W-1:0] n2_reg;

    // Stage 3: total days and minutes within the day.
    logic [tsmd_pkg::DAYS_W-1:0]   days3_reg, days3_next;
    logic [10:0]                   hm3_reg, hm3_next;

    // Stage 4: minute count.
    logic [tsmd_pkg::MINS_W-1:0]   mins4_reg, mins4_next;

    logic [14:0] ysum3;
    logic [13:0] q_x100;
    logic [7:0]  ceil100;
    logic [5:0]  ceil400;
    logic        div400;
    logic        leap;
    logic [12:0] leaps;

    always_comb
    begin
        prod1_next = PROD_W'(year[tsmd_pkg::YEAR_W-1:2]) * PROD_W'(tsmd_pkg::RECIP25);
    end

    always_comb
    begin
        q2_next       = prod1_reg[PROD_W-1:tsmd_pkg::RECIP25_SHIFT];
        q_x100        = 14'(14'(q2_next) * 14'd100);
        div100_2_next = (y1_reg == q_x100);
        div4_2_next   = (y1_reg[1:0] == 2'd0);
        ysum3         = 15'(y1_reg) + 15'd3;
        ceil4_2_next  = ysum3[14:2];
        yd2_next      = tsmd_pkg::DAYS_W'(y1_reg) *
                        tsmd_pkg::DAYS_W'(tsmd_pkg::DAYS_PER_YEAR);
        md2_next      = 10'(tsmd_pkg::DAYS_BEFORE_MONTH[m1_reg]) + 10'(d1_reg);
        late2_next    = (m1_reg >= tsmd_pkg::MONTH_MARCH);
    end

    always_comb
    begin
        div400     = div100_2_reg && (q2_reg[1:0] == 2'd0);
        leap       = (div4_2_reg && !div100_2_reg) || div400;
        ceil100    = q2_reg + 8'(!div100_2_reg);
        ceil400    = 6'(q2_reg[Q_W-1:2]) + 6'(!div400);
        leaps      = ceil4_2_reg - 13'(ceil100) + 13'(ceil400);
        days3_next = yd2_reg + tsmd_pkg::DAYS_W'(leaps) + tsmd_pkg::DAYS_W'(md2_reg)
                     + tsmd_pkg::DAYS_W'(late2_reg && leap);
        hm3_next   = 11'(11'(h2_reg) * 11'(tsmd_pkg::MINUTES_PER_HOUR)) + 11'(n2_reg);
    end

    always_comb
    begin
        mins4_next = tsmd_pkg::MINS_W'(days3_reg) *
                     tsmd_pkg::MINS_W'(tsmd_pkg::MINUTES_PER_DAY)
                     + tsmd_pkg::MINS_W'(hm3_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            y1_reg    <= year;
            m1_reg    <= month;
            d1_reg    <= day;
            h1_reg    <= hour;
            n1_reg    <= minute;
            prod1_reg <= prod1_next;
        end
        if (adv.s2)
        begin
            q2_reg       <= q2_next;
            div100_2_reg <= div100_2_next;
            div4_2_reg   <= div4_2_next;
            ceil4_2_reg  <= ceil4_2_next;
            yd2_reg      <= yd2_next;
            md2_reg      <= md2_next;
            late2_reg    <= late2_next;
            h2_reg       <= h1_reg;
            n2_reg       <= n1_reg;
        end
        if (adv.s3)
        begin
            days3_reg <= days3_next;
            hm3_reg   <= hm3_next;
        end
        if (adv.s4)
        begin
            mins4_reg <= mins4_next;
        end
    end

    assign mins = mins4_reg;

endmodule
`default_nettype wire
